// File: hw/rtl/htie_pkg.sv
// shared types, widths and codes for the header table index and evict block
package htie_pkg;

    // default sizes of the table
    localparam int DEF_MAX_ENTRIES    = 2048;
    localparam int DEF_STATIC_ENTRIES = 61;

    // field widths
    localparam int OP_W      = 2;
    localparam int IDX_W     = 32;
    localparam int LEN_W     = 16;
    localparam int REF_W     = 32;
    localparam int SIZE_W    = 17;
    localparam int COST_W    = 18;
    localparam int SIDX_W    = 6;
    localparam int CNT_OUT_W = 12;

    // size limit after reset and the fixed per entry overhead
    localparam logic [SIZE_W-1:0] MAX_SIZE_RESET = 17'd4096;
    localparam logic [COST_W-1:0] ENTRY_OVERHEAD = 18'd32;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_TRIM   = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LK_DATA,
        ST_EV_CHECK,
        ST_EV_APPLY,
        ST_FINISH
    } state_t;

    // one stored table entry
    typedef struct packed {
        logic [REF_W-1:0] string_ref;
        logic [LEN_W-1:0] name_length;
        logic [LEN_W-1:0] value_length;
    } entry_t;

    // lookup part of a result item
    typedef struct packed {
        logic              status;
        logic              from_static;
        logic [SIDX_W-1:0] static_index;
        logic [REF_W-1:0]  found_ref;
        logic [LEN_W-1:0]  found_name_length;
        logic [LEN_W-1:0]  found_value_length;
    } lookup_res_t;

endpackage

// File: hw/rtl/htie_if.sv
// handshake channels of the header table index and evict block

// configuration write channel
interface htie_cfg_if;
    import htie_pkg::*;
    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] max_table_size;

    modport source (output valid, output max_table_size, input ready);
    modport sink (input valid, input max_table_size, output ready);
endinterface

// request channel, one item per operation
interface htie_req_if;
    import htie_pkg::*;
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [IDX_W-1:0] lookup_index;
    logic [LEN_W-1:0] name_length;
    logic [LEN_W-1:0] value_length;
    logic [REF_W-1:0] string_ref;

    modport source (output valid, output operation, output lookup_index,
                    output name_length, output value_length, output string_ref,
                    input ready);
    modport sink (input valid, input operation, input lookup_index,
                  input name_length, input value_length, input string_ref,
                  output ready);
endinterface

// response channel, one item per request
interface htie_rsp_if;
    import htie_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 status;
    logic                 from_static;
    logic [SIDX_W-1:0]    static_index;
    logic [REF_W-1:0]     found_ref;
    logic [LEN_W-1:0]     found_name_length;
    logic [LEN_W-1:0]     found_value_length;
    logic [SIZE_W-1:0]    used_size;
    logic [CNT_OUT_W-1:0] entry_count;

    modport source (output valid, output status, output from_static,
                    output static_index, output found_ref, output found_name_length,
                    output found_value_length, output used_size, output entry_count,
                    input ready);
    modport sink (input valid, input status, input from_static,
                  input static_index, input found_ref, input found_name_length,
                  input found_value_length, input used_size, input entry_count,
                  output ready);
endinterface

// File: hw/rtl/header_table_index_and_evict_core.sv
// dynamic header table bookkeeping: ring of entries in one memory, eviction and lookup
//
// channel  dir  handshake          carries
// cfg      in   valid/ready        max_table_size, always ready
// req      in   valid/ready        operation, lookup_index, lengths, string_ref
// rsp      out  valid/ready        status, static/dynamic hit fields, used_size, entry_count
//
// nop, static hit, invalid index and oversize insert pass decode, then finish; a dynamic lookup
// adds a data state; insert and trim pass an evict check, with a read, then an apply, for each
// evicted entry, as every eviction reads the oldest entry's lengths through the single memory read port.
// reset clears pointer, count, size and handshake state and loads the reset limit; the memory
// is not cleared, since only entries below the count are ever read.
// a finished result sits in the output register; the next item is taken while it waits,
// and that item's result holds in its last state until the output register is free.
module header_table_index_and_evict_core #(
    parameter int MAX_ENTRIES    = htie_pkg::DEF_MAX_ENTRIES,
    parameter int STATIC_ENTRIES = htie_pkg::DEF_STATIC_ENTRIES
) (
    input  logic       clk,
    input  logic       rst_n,
    htie_cfg_if.sink   cfg,
    htie_req_if.sink   req,
    htie_rsp_if.source rsp
);
    import htie_pkg::*;

    localparam int PTR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [PTR_W:0]     RING_DEPTH  = (PTR_W + 1)'(MAX_ENTRIES);
    localparam logic [CNT_W-1:0]   CNT_FULL    = CNT_W'(MAX_ENTRIES);
    localparam logic [PTR_W-1:0]   PTR_LAST    = PTR_W'(MAX_ENTRIES - 1);
    localparam logic [IDX_W-1:0]   STATIC_LAST = IDX_W'(STATIC_ENTRIES);

    // ring slot of the entry k places older than the newest
    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
                                                 input logic [PTR_W-1:0] k);
        logic [PTR_W:0] sum;
        sum = {1'b0, base} + {1'b0, k};
        if (sum >= RING_DEPTH)
        begin
            sum = sum - RING_DEPTH;
        end
        return sum[PTR_W-1:0];
    endfunction

    // accounted cost of an entry
    function automatic logic [COST_W-1:0] entry_cost(input entry_t e);
        return COST_W'(e.name_length) + COST_W'(e.value_length) + ENTRY_OVERHEAD;
    endfunction

    // control state
    state_t            state_reg, state_next;
    logic [PTR_W-1:0]  newest_reg, newest_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [SIZE_W-1:0] max_size_reg;
    logic              out_valid_reg, out_valid_next;

    // item payload and working values
    op_t               op_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [LEN_W-1:0]  nlen_reg;
    logic [LEN_W-1:0]  vlen_reg;
    logic [REF_W-1:0]  sref_reg;
    logic [COST_W-1:0] cost_reg;
    logic [SIZE_W-1:0] target_reg, target_next;
    lookup_res_t       res_reg, res_next;

    // output register
    lookup_res_t          out_res_reg;
    logic [SIZE_W-1:0]    out_size_reg;
    logic [CNT_OUT_W-1:0] out_count_reg;

    // entry memory
    entry_t            mem [MAX_ENTRIES];
    entry_t            rd_data_reg;
    logic              rd_en;
    logic [PTR_W-1:0]  rd_addr;
    logic              wr_en;
    logic [PTR_W-1:0]  wr_addr;
    entry_t            wr_data;

    // derived values
    logic              accept;
    logic              out_free;
    logic              idx_zero;
    logic              idx_static;
    logic [IDX_W-1:0]  dyn_idx;
    logic [IDX_W-1:0]  dyn_off;
    logic              dyn_out;
    logic              lk_hit;
    logic [PTR_W-1:0]  lk_addr;
    logic [CNT_W-1:0]  cnt_m1;
    logic [PTR_W-1:0]  ev_addr;
    logic              ev_more;
    logic              ins_fits;
    logic [PTR_W-1:0]  newest_dec;
    logic [COST_W-1:0] ev_cost;
    logic [COST_W-1:0] size_ext;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    // lookup index decode
    assign idx_zero   = (idx_reg == '0);
    assign idx_static = (idx_reg <= STATIC_LAST);
    assign dyn_idx    = idx_reg - STATIC_LAST;
    assign dyn_off    = dyn_idx - 32'd1;
    assign dyn_out    = (dyn_idx > IDX_W'(count_reg));
    assign lk_hit     = !idx_zero && !idx_static && !dyn_out;
    assign lk_addr    = slot_of(newest_reg, dyn_off[PTR_W-1:0]);

    // eviction control
    assign cnt_m1   = count_reg - 1'b1;
    assign ev_addr  = slot_of(newest_reg, cnt_m1[PTR_W-1:0]);
    assign ev_more  = (count_reg != '0) &&
                      ((size_reg > target_reg) ||
                       ((op_reg == OP_INSERT) && (count_reg == CNT_FULL)));
    assign ins_fits = (cost_reg <= COST_W'(max_size_reg));
    assign newest_dec = (newest_reg == '0) ? PTR_LAST : newest_reg - 1'b1;
    assign ev_cost  = entry_cost(rd_data_reg);
    assign size_ext = COST_W'(size_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (op_reg)
                    OP_INSERT: state_next = ins_fits ? ST_EV_CHECK : ST_FINISH;
                    OP_LOOKUP: state_next = lk_hit ? ST_LK_DATA : ST_FINISH;
                    OP_TRIM:   state_next = ST_EV_CHECK;
                    default:   state_next = ST_FINISH;
                endcase
            end
            ST_LK_DATA:  state_next = ST_FINISH;
            ST_EV_CHECK: state_next = ev_more ? ST_EV_APPLY : ST_FINISH;
            ST_EV_APPLY: state_next = ST_EV_CHECK;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // handshake and memory port control
    always_comb
    begin
        req.ready = (state_reg == ST_IDLE);
        rd_en     = 1'b0;
        rd_addr   = ev_addr;
        wr_en     = 1'b0;
        wr_addr   = newest_dec;
        wr_data   = '{string_ref: sref_reg, name_length: nlen_reg, value_length: vlen_reg};
        case (state_reg)
            ST_DECODE:
            begin
                if ((op_reg == OP_LOOKUP) && lk_hit)
                begin
                    rd_en   = 1'b1;
                    rd_addr = lk_addr;
                end
            end
            ST_EV_CHECK:
            begin
                if (ev_more)
                begin
                    rd_en = 1'b1;
                end
                else if (op_reg == OP_INSERT)
                begin
                    wr_en = 1'b1;
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // table bookkeeping and result assembly
    always_comb
    begin
        newest_next    = newest_reg;
        count_next     = count_reg;
        size_next      = size_reg;
        target_next    = target_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_DECODE:
            begin
                res_next = '0;
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (ins_fits)
                        begin
                            target_next = SIZE_W'(COST_W'(max_size_reg) - cost_reg);
                        end
                        else
                        begin
                            count_next = '0;
                            size_next  = '0;
                        end
                    end
                    OP_LOOKUP:
                    begin
                        if (idx_zero)
                        begin
                            res_next.status = 1'b1;
                        end
                        else if (idx_static)
                        begin
                            res_next.from_static  = 1'b1;
                            res_next.static_index = idx_reg[SIDX_W-1:0];
                        end
                        else if (dyn_out)
                        begin
                            res_next.status = 1'b1;
                        end
                    end
                    OP_TRIM:
                    begin
                        target_next = max_size_reg;
                    end
                    default:
                    begin
                        target_next = target_reg;
                    end
                endcase
            end
            ST_LK_DATA:
            begin
                res_next.found_ref          = rd_data_reg.string_ref;
                res_next.found_name_length  = rd_data_reg.name_length;
                res_next.found_value_length = rd_data_reg.value_length;
            end
            ST_EV_CHECK:
            begin
                if (!ev_more && (op_reg == OP_INSERT))
                begin
                    newest_next = newest_dec;
                    count_next  = count_reg + 1'b1;
                    size_next   = SIZE_W'(size_ext + cost_reg);
                end
            end
            ST_EV_APPLY:
            begin
                size_next  = (size_ext >= ev_cost) ? SIZE_W'(size_ext - ev_cost) : '0;
                count_next = cnt_m1;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            newest_reg    <= '0;
            count_reg     <= '0;
            size_reg      <= '0;
            max_size_reg  <= MAX_SIZE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            newest_reg    <= newest_next;
            count_reg     <= count_next;
            size_reg      <= size_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                max_size_reg <= cfg.max_table_size;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op_t'(req.operation);
            idx_reg  <= req.lookup_index;
            nlen_reg <= req.name_length;
            vlen_reg <= req.value_length;
            sref_reg <= req.string_ref;
            cost_reg <= COST_W'(req.name_length) + COST_W'(req.value_length) + ENTRY_OVERHEAD;
        end
        target_reg <= target_next;
        res_reg    <= res_next;
        if ((state_reg == ST_FINISH) && out_free)
        begin
            out_res_reg   <= res_reg;
            out_size_reg  <= size_reg;
            out_count_reg <= CNT_OUT_W'(count_reg);
        end
    end

    // entry memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // port drive
    assign cfg.ready              = 1'b1;
    assign rsp.valid              = out_valid_reg;
    assign rsp.status             = out_res_reg.status;
    assign rsp.from_static        = out_res_reg.from_static;
    assign rsp.static_index       = out_res_reg.static_index;
    assign rsp.found_ref          = out_res_reg.found_ref;
    assign rsp.found_name_length  = out_res_reg.found_name_length;
    assign rsp.found_value_length = out_res_reg.found_value_length;
    assign rsp.used_size          = out_size_reg;
    assign rsp.entry_count        = out_count_reg;

    // an accepted item is decoded in the next cycle
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_DECODE))
        else $error("accepted item not decoded");

    // each eviction removes exactly one entry
    a_evict_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EV_APPLY) |=> (count_reg == $past(cnt_m1)))
        else $error("eviction did not drop one entry");

    // a result only appears from the finishing state
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("result raised outside finishing state");

    // the memory is never read and written in the same cycle
    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && wr_en))
        else $error("memory read and write collide");

    // the ring never holds more entries than slots
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= CNT_FULL))
        else $error("entry count beyond ring depth");

endmodule

// File: test/header_table_index_and_evict_core_tb.sv
// self-checking testbench for the dynamic header table index and evict block
module header_table_index_and_evict_core_tb;
    import htie_pkg::*;

    localparam int TBL_DEPTH    = DEF_MAX_ENTRIES;
    localparam int STATIC_COUNT = DEF_STATIC_ENTRIES;
    localparam int TAIL_CYCLES  = 20;

    // response status code for a bad index
    localparam logic RSP_BAD_INDEX = 1'b1;

    // one predicted response item
    typedef struct packed {
        lookup_res_t          lk;
        logic [SIZE_W-1:0]    used_size;
        logic [CNT_OUT_W-1:0] entry_count;
    } table_result_t;

    logic clk;
    logic rst_n;

    htie_cfg_if cfg_ch ();
    htie_req_if req_ch ();
    htie_rsp_if rsp_ch ();

    header_table_index_and_evict_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // predicted table: newest-first ring with byte accounting
    entry_t      ring_mem [TBL_DEPTH];
    int unsigned ring_head;
    int unsigned ring_fill;
    int unsigned ring_bytes;
    int unsigned size_limit;

    table_result_t pending_results [$];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int items_sent;
    int results_seen;
    int limit_writes;
    int peak_fill;
    int evicted_total;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #4000000;
        $display("header_table_index_and_evict_core_tb NOT OK");
        $finish;
    end

    // receiver: random back-pressure on the response channel
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // predictor helpers
    function automatic int unsigned cost_of_entry(entry_t e);
        return e.name_length + e.value_length + ENTRY_OVERHEAD;
    endfunction

    function automatic void drop_oldest_entry();
        int unsigned c;
        if (ring_fill == 0)
            return;
        c = cost_of_entry(ring_mem[(ring_head + ring_fill - 1) % TBL_DEPTH]);
        ring_bytes = (ring_bytes >= c) ? ring_bytes - c : 0;
        ring_fill--;
        evicted_total++;
    endfunction

    function automatic void evict_down_to(int unsigned target);
        while (ring_bytes > target && ring_fill > 0)
            drop_oldest_entry();
    endfunction

    // apply one item to the predicted table and return its response
    function automatic table_result_t predict_item(op_t op, logic [IDX_W-1:0] idx,
                                                   logic [LEN_W-1:0] nlen,
                                                   logic [LEN_W-1:0] vlen,
                                                   logic [REF_W-1:0] sref);
        table_result_t r;
        int unsigned   cost;
        int unsigned   dyn;
        entry_t        e;
        r = '0;
        case (op)
            OP_INSERT:
            begin
                cost = nlen + vlen + ENTRY_OVERHEAD;
                if (cost > size_limit)
                begin
                    ring_fill  = 0;
                    ring_bytes = 0;
                end
                else
                begin
                    evict_down_to(size_limit - cost);
                    if (ring_fill >= TBL_DEPTH)
                        drop_oldest_entry();
                    ring_head = (ring_head == 0) ? TBL_DEPTH - 1 : ring_head - 1;
                    ring_mem[ring_head] = '{string_ref: sref, name_length: nlen,
                                            value_length: vlen};
                    ring_fill++;
                    ring_bytes += cost;
                end
            end
            OP_LOOKUP:
            begin
                if (idx == 0)
                    r.lk.status = RSP_BAD_INDEX;
                else if (idx <= STATIC_COUNT)
                begin
                    r.lk.from_static  = 1'b1;
                    r.lk.static_index = idx[SIDX_W-1:0];
                end
                else
                begin
                    dyn = idx - STATIC_COUNT;
                    if (dyn > ring_fill)
                        r.lk.status = RSP_BAD_INDEX;
                    else
                    begin
                        e = ring_mem[(ring_head + dyn - 1) % TBL_DEPTH];
                        r.lk.found_ref          = e.string_ref;
                        r.lk.found_name_length  = e.name_length;
                        r.lk.found_value_length = e.value_length;
                    end
                end
            end
            OP_TRIM:
                evict_down_to(size_limit);
            default:
                ;
        endcase
        if (ring_fill > peak_fill)
            peak_fill = ring_fill;
        r.used_size   = ring_bytes[SIZE_W-1:0];
        r.entry_count = ring_fill[CNT_OUT_W-1:0];
        return r;
    endfunction

    // send one item; called and returns at a falling edge, valid left high
    task automatic send_item(op_t op, logic [IDX_W-1:0] idx, logic [LEN_W-1:0] nlen,
                             logic [LEN_W-1:0] vlen, logic [REF_W-1:0] sref);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.operation    <= op;
        req_ch.lookup_index <= idx;
        req_ch.name_length  <= nlen;
        req_ch.value_length <= vlen;
        req_ch.string_ref   <= sref;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_results.push_back(predict_item(op, idx, nlen, vlen, sref));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_insert(logic [LEN_W-1:0] nlen, logic [LEN_W-1:0] vlen,
                               logic [REF_W-1:0] sref);
        send_item(OP_INSERT, $urandom, nlen, vlen, sref);
    endtask

    task automatic send_lookup(logic [IDX_W-1:0] idx);
        send_item(OP_LOOKUP, idx, LEN_W'($urandom), LEN_W'($urandom), $urandom);
    endtask

    task automatic send_plain(op_t op);
        send_item(op, $urandom, LEN_W'($urandom), LEN_W'($urandom), $urandom);
    endtask

    // stop sending and wait until every response has come back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results.size() != 0);
    endtask

    // write the size limit; only called once the block is idle
    task automatic write_limit(logic [SIZE_W-1:0] lim);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.max_table_size <= lim;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        size_limit = lim;
        limit_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // one random item, mostly small inserts and lookups into the live range
    task automatic send_random_item();
        int unsigned pick;
        int unsigned sel;
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            sel = $urandom_range(99);
            if (sel < 85)
                send_insert(LEN_W'($urandom_range(40)), LEN_W'($urandom_range(60)), $urandom);
            else if (sel < 95)
                send_insert(LEN_W'($urandom_range(2000)), LEN_W'($urandom_range(2000)),
                            $urandom);
            else
                send_insert(LEN_W'($urandom), LEN_W'($urandom), $urandom);
        end
        else if (pick < 80)
        begin
            sel = $urandom_range(99);
            if (sel < 10)
                send_lookup(0);
            else if (sel < 30)
                send_lookup($urandom_range(STATIC_COUNT, 1));
            else if (sel < 85 && ring_fill > 0)
                send_lookup($urandom_range(STATIC_COUNT + ring_fill, STATIC_COUNT + 1));
            else if (sel < 95)
                send_lookup($urandom_range(STATIC_COUNT + ring_fill + 3,
                                           STATIC_COUNT + ring_fill + 1));
            else
                send_lookup($urandom);
        end
        else if (pick < 92)
            send_plain(OP_TRIM);
        else
            send_plain(OP_NOP);
        // now and then hold off until the block has emptied
        if ($urandom_range(99) < 2)
            wait_drained();
    endtask

    task automatic run_random(int count);
        repeat (count)
            send_random_item();
    endtask

    // lookups on an empty table, no operation and trim
    task automatic test_empty_table();
        send_lookup(0);
        send_lookup(1);
        send_lookup(STATIC_COUNT);
        send_lookup(STATIC_COUNT + 1);
        send_lookup(32'hFFFF_FFFF);
        send_plain(OP_NOP);
        send_plain(OP_TRIM);
    endtask

    // oversize inserts clear the table, normal inserts evict the oldest
    task automatic test_insert_evict();
        send_insert(16'd0, 16'd0, 32'h0000_0000);
        send_insert(16'hFFFF, 16'd0, 32'hFFFF_FFFF);
        send_insert(16'd0, 16'hFFFF, 32'h5A5A_A5A5);
        send_insert(16'd2000, 16'd2000, 32'h1234_5678);
        send_insert(16'd10, 16'd20, 32'hCAFE_0001);
        send_insert(16'd0, 16'd0, 32'hCAFE_0002);
        send_lookup(STATIC_COUNT + 1);
        send_lookup(STATIC_COUNT + 2);
        send_lookup(STATIC_COUNT + 3);
        send_plain(OP_TRIM);
    endtask

    // limit at zero, at exactly one empty entry, and at 65536
    task automatic test_limit_extremes();
        wait_drained();
        write_limit(17'd0);
        send_insert(16'd0, 16'd0, $urandom);
        wait_drained();
        write_limit(17'd32);
        send_insert(16'd0, 16'd0, $urandom);
        send_insert(16'd0, 16'd0, $urandom);
        send_lookup(STATIC_COUNT + 1);
        wait_drained();
        write_limit(17'd65536);
        send_insert(16'd65504, 16'd0, $urandom);
        send_lookup(STATIC_COUNT + 1);
        send_insert(16'd1, 16'd1, $urandom);
    endtask

    // random mix while the limit moves between settings
    task automatic test_random_mix();
        run_random(130);
        wait_drained();
        write_limit(17'd1000);
        send_idle_pct = 68;
        recv_idle_pct = 23;
        run_random(120);
        wait_drained();
        write_limit(SIZE_W'($urandom_range(20000, 200)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(100);
    endtask

    // many cheap entries, deep lookups, then a long trim down to a tiny limit
    task automatic test_bulk_trim();
        wait_drained();
        write_limit(17'd65536);
        repeat (120)
        begin
            send_insert(LEN_W'($urandom_range(3)), LEN_W'($urandom_range(3)), $urandom);
            if ($urandom_range(3) == 0)
                send_lookup($urandom_range(STATIC_COUNT + ring_fill + 1, STATIC_COUNT + 1));
        end
        send_lookup(STATIC_COUNT + ring_fill);
        wait_drained();
        write_limit(17'd64);
        send_plain(OP_TRIM);
        send_lookup(STATIC_COUNT + 1);
        send_lookup(STATIC_COUNT + 2);
        send_lookup(STATIC_COUNT + 3);
        wait_drained();
        write_limit(17'd0);
        send_plain(OP_TRIM);
        send_insert(16'd0, 16'd0, $urandom);
        run_random(10);
    endtask

    task automatic report_field(string name, longint unsigned want, longint unsigned got);
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        mismatches++;
    endtask

    // compare each response item with the oldest prediction
    always @(posedge clk)
    begin : check_results
        table_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: response item with none expected, expected nothing actual %0h",
                         $time, rsp_ch.used_size);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.status !== want.lk.status)
                    report_field("status", want.lk.status, rsp_ch.status);
                if (rsp_ch.from_static !== want.lk.from_static)
                    report_field("from_static", want.lk.from_static, rsp_ch.from_static);
                if (rsp_ch.static_index !== want.lk.static_index)
                    report_field("static_index", want.lk.static_index, rsp_ch.static_index);
                if (rsp_ch.found_ref !== want.lk.found_ref)
                    report_field("found_ref", want.lk.found_ref, rsp_ch.found_ref);
                if (rsp_ch.found_name_length !== want.lk.found_name_length)
                    report_field("found_name_length", want.lk.found_name_length,
                                 rsp_ch.found_name_length);
                if (rsp_ch.found_value_length !== want.lk.found_value_length)
                    report_field("found_value_length", want.lk.found_value_length,
                                 rsp_ch.found_value_length);
                if (rsp_ch.used_size !== want.used_size)
                    report_field("used_size", want.used_size, rsp_ch.used_size);
                if (rsp_ch.entry_count !== want.entry_count)
                    report_field("entry_count", want.entry_count, rsp_ch.entry_count);
            end
        end
    end

    // reset, test sequence and verdict
    initial
    begin
        rst_n                 = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.max_table_size = '0;
        req_ch.valid          = 1'b0;
        req_ch.operation      = OP_NOP;
        req_ch.lookup_index   = '0;
        req_ch.name_length    = '0;
        req_ch.value_length   = '0;
        req_ch.string_ref     = '0;
        ring_head             = 0;
        ring_fill             = 0;
        ring_bytes            = 0;
        size_limit            = MAX_SIZE_RESET;
        send_idle_pct         = 23;
        recv_idle_pct         = 68;
        mismatches            = 0;
        items_sent            = 0;
        results_seen          = 0;
        limit_writes          = 0;
        peak_fill             = 0;
        evicted_total         = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_table();
        test_insert_evict();
        test_limit_extremes();
        test_random_mix();
        test_bulk_trim();

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("ran %0d items, checked %0d responses, %0d limit writes",
                 items_sent, results_seen, limit_writes);
        $display("table reached %0d entries, %0d entries evicted in total",
                 peak_fill, evicted_total);
        if (mismatches == 0)
            $display("header_table_index_and_evict_core_tb OK");
        else
            $display("header_table_index_and_evict_core_tb NOT OK");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/htie_pkg.sv
hw/rtl/htie_if.sv
hw/rtl/header_table_index_and_evict_core.sv
test/header_table_index_and_evict_core_tb.sv
